// ----- src/cwp_pkg.sv -----
// Package of the collinear waypoint pruner.
// Holds the default widths, the queue depth and the request kinds shared by
// the front, the back and the top level. Depends on nothing.
`default_nettype none

package cwp_pkg;

  // Default coordinate widths.
  localparam int HORIZ_BITS_DEF  = 24;
  localparam int HEIGHT_BITS_DEF = 16;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // What the back has to do with one queued request.
  typedef enum logic [2:0] {
    KIND_FIRST,       // first point of a longer path: pass it on
    KIND_SINGLE,      // one-point path: pass the point on twice
    KIND_MIDDLE,      // decide the pending middle point
    KIND_LAST_SHORT,  // last point of a two-point path
    KIND_LAST_LONG    // decide the middle point, then pass the last point on
  } kind_e;

endpackage

`default_nettype wire

// ----- src/cwp_queue.sv -----
// Short request queue between the front and the back of the waypoint pruner.
// Generic width and depth, valid/ready on both sides. Uses no package.
`default_nettype none

module cwp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push, pop;

  // Handshakes on both sides.
  assign push_ready_o = (count_q != CntW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = store_q[rd_ptr_q];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      store_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ----- src/cwp_front.sv -----
// Front of the waypoint pruner: accepts waypoints, keeps the two-point window
// and turns each waypoint, but the second of a longer path, into a queued
// request with its segment deltas. Depends on cwp_pkg.
`default_nettype none

module cwp_front
  import cwp_pkg::*;
#(
  parameter int HORIZ_BITS  = HORIZ_BITS_DEF,
  parameter int HEIGHT_BITS = HEIGHT_BITS_DEF,
  localparam int EntryW = $bits(kind_e) + 1 + 4 * (HORIZ_BITS + 1)
                          + 4 * HORIZ_BITS + 2 * HEIGHT_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [HORIZ_BITS-1:0]  point_x_i,
  input  logic signed [HEIGHT_BITS-1:0] point_y_i,
  input  logic signed [HORIZ_BITS-1:0]  point_z_i,
  input  logic                          path_last_i,
  output logic                          push_valid_o,
  input  logic                          push_ready_i,
  output logic [EntryW-1:0]             push_data_o
);

  // Request layout, identical in the back.
  typedef struct packed {
    kind_e                 kind;
    logic                  ybreak;
    logic [HORIZ_BITS:0]   ax;
    logic [HORIZ_BITS:0]   az;
    logic [HORIZ_BITS:0]   bx;
    logic [HORIZ_BITS:0]   bz;
    logic [HORIZ_BITS-1:0] mid_x;
    logic [HEIGHT_BITS-1:0] mid_y;
    logic [HORIZ_BITS-1:0] mid_z;
    logic [HORIZ_BITS-1:0] pt_x;
    logic [HEIGHT_BITS-1:0] pt_y;
    logic [HORIZ_BITS-1:0] pt_z;
  } entry_t;

  logic [1:0]             seen_q, seen_d;
  logic [HORIZ_BITS-1:0]  before_x_q, before_z_q, middle_x_q, middle_z_q;
  logic [HEIGHT_BITS-1:0] before_y_q, middle_y_q;
  logic                   accept;
  logic                   needs_push;
  entry_t                 entry;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Classify the waypoint by its place in the path and form its request.
  always_comb begin
    entry.kind = KIND_FIRST;
    needs_push = 1'b1;
    case (seen_q)
      2'd0: entry.kind = path_last_i ? KIND_SINGLE : KIND_FIRST;
      2'd1: begin
        entry.kind = KIND_LAST_SHORT;
        needs_push = path_last_i;
      end
      default: entry.kind = path_last_i ? KIND_LAST_LONG : KIND_MIDDLE;
    endcase

    // Segment deltas, sign-extended by one bit so they cannot overflow.
    entry.ax = {middle_x_q[HORIZ_BITS-1], middle_x_q}
             - {before_x_q[HORIZ_BITS-1], before_x_q};
    entry.az = {middle_z_q[HORIZ_BITS-1], middle_z_q}
             - {before_z_q[HORIZ_BITS-1], before_z_q};
    entry.bx = {point_x_i[HORIZ_BITS-1], point_x_i}
             - {middle_x_q[HORIZ_BITS-1], middle_x_q};
    entry.bz = {point_z_i[HORIZ_BITS-1], point_z_i}
             - {middle_z_q[HORIZ_BITS-1], middle_z_q};
    entry.ybreak = (middle_y_q != before_y_q) || (middle_y_q != point_y_i);
    entry.mid_x  = middle_x_q;
    entry.mid_y  = middle_y_q;
    entry.mid_z  = middle_z_q;
    entry.pt_x   = point_x_i;
    entry.pt_y   = point_y_i;
    entry.pt_z   = point_z_i;
  end

  assign push_valid_o = accept && needs_push;
  assign push_data_o  = entry;

  // Points seen in the current path, back to zero after the last point.
  always_comb begin
    seen_d = seen_q;
    if (accept) begin
      if (path_last_i) begin
        seen_d = 2'd0;
      end else if (seen_q != 2'd2) begin
        seen_d = seen_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= 2'd0;
      before_x_q <= '0;
      before_y_q <= '0;
      before_z_q <= '0;
      middle_x_q <= '0;
      middle_y_q <= '0;
      middle_z_q <= '0;
    end else begin
      seen_q <= seen_d;
      // Shift the window; after the last point it is cleared.
      if (accept) begin
        if (path_last_i) begin
          before_x_q <= '0;
          before_y_q <= '0;
          before_z_q <= '0;
          middle_x_q <= '0;
          middle_y_q <= '0;
          middle_z_q <= '0;
        end else begin
          before_x_q <= middle_x_q;
          before_y_q <= middle_y_q;
          before_z_q <= middle_z_q;
          middle_x_q <= point_x_i;
          middle_y_q <= point_y_i;
          middle_z_q <= point_z_i;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/cwp_back.sv -----
// Back of the waypoint pruner: forms the two cross-product terms of each
// request, decides the middle point and emits zero, one or two kept points
// through an output register. Depends on cwp_pkg.
`default_nettype none

module cwp_back
  import cwp_pkg::*;
#(
  parameter int HORIZ_BITS  = HORIZ_BITS_DEF,
  parameter int HEIGHT_BITS = HEIGHT_BITS_DEF,
  localparam int EntryW = $bits(kind_e) + 1 + 4 * (HORIZ_BITS + 1)
                          + 4 * HORIZ_BITS + 2 * HEIGHT_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          pop_valid_i,
  output logic                          pop_ready_o,
  input  logic [EntryW-1:0]             pop_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [HORIZ_BITS-1:0]  kept_x_o,
  output logic signed [HEIGHT_BITS-1:0] kept_y_o,
  output logic signed [HORIZ_BITS-1:0]  kept_z_o,
  output logic                          path_end_o,
  output logic                          run_last_o
);

  localparam int ProdW = 2 * (HORIZ_BITS + 1);

  // Request layout, identical in the front.
  typedef struct packed {
    kind_e                 kind;
    logic                  ybreak;
    logic [HORIZ_BITS:0]   ax;
    logic [HORIZ_BITS:0]   az;
    logic [HORIZ_BITS:0]   bx;
    logic [HORIZ_BITS:0]   bz;
    logic [HORIZ_BITS-1:0] mid_x;
    logic [HEIGHT_BITS-1:0] mid_y;
    logic [HORIZ_BITS-1:0] mid_z;
    logic [HORIZ_BITS-1:0] pt_x;
    logic [HEIGHT_BITS-1:0] pt_y;
    logic [HORIZ_BITS-1:0] pt_z;
  } entry_t;

  // Request with its products, held in the product register.
  typedef struct packed {
    kind_e                 kind;
    logic                  ybreak;
    logic [ProdW-1:0]      p1;
    logic [ProdW-1:0]      p2;
    logic [HORIZ_BITS-1:0] mid_x;
    logic [HEIGHT_BITS-1:0] mid_y;
    logic [HORIZ_BITS-1:0] mid_z;
    logic [HORIZ_BITS-1:0] pt_x;
    logic [HEIGHT_BITS-1:0] pt_y;
    logic [HORIZ_BITS-1:0] pt_z;
  } stage_t;

  // One kept point on its way out.
  typedef struct packed {
    logic [HORIZ_BITS-1:0]  x;
    logic [HEIGHT_BITS-1:0] y;
    logic [HORIZ_BITS-1:0]  z;
    logic                   path_end;
    logic                   run_last;
  } result_t;

  entry_t                  req;
  stage_t                  stage_q, stage_d;
  logic                    stage_valid_q;
  logic                    phase_q, phase_d;
  logic                    out_valid_q, out_valid_d;
  result_t                 out_q;
  logic signed [ProdW-1:0] prod1, prod2;
  logic                    keep;
  logic [1:0]              n_results;
  result_t                 res0, res1, res_sel;
  logic                    final_result;
  logic                    out_free;
  logic                    consume;
  logic                    load_out;

  assign req = pop_data_i;

  // Exact cross-product terms; equal terms mean the xz turn is zero.
  assign prod1 = $signed(req.ax) * $signed(req.bz);
  assign prod2 = $signed(req.az) * $signed(req.bx);

  always_comb begin
    stage_d.kind   = req.kind;
    stage_d.ybreak = req.ybreak;
    stage_d.p1     = prod1;
    stage_d.p2     = prod2;
    stage_d.mid_x  = req.mid_x;
    stage_d.mid_y  = req.mid_y;
    stage_d.mid_z  = req.mid_z;
    stage_d.pt_x   = req.pt_x;
    stage_d.pt_y   = req.pt_y;
    stage_d.pt_z   = req.pt_z;
  end

  // The middle point stays when the path turns or changes height.
  assign keep = (stage_q.p1 != stage_q.p2) || stage_q.ybreak;

  // Results that the held request produces, in order.
  always_comb begin
    res0 = '{x: stage_q.pt_x, y: stage_q.pt_y, z: stage_q.pt_z,
             path_end: 1'b1, run_last: 1'b1};
    res1 = res0;
    n_results = 2'd0;
    case (stage_q.kind)
      KIND_FIRST: begin
        n_results     = 2'd1;
        res0.path_end = 1'b0;
      end
      KIND_SINGLE: begin
        n_results     = 2'd2;
        res0.path_end = 1'b0;
        res0.run_last = 1'b0;
      end
      KIND_MIDDLE: begin
        n_results = keep ? 2'd1 : 2'd0;
        res0      = '{x: stage_q.mid_x, y: stage_q.mid_y, z: stage_q.mid_z,
                      path_end: 1'b0, run_last: 1'b1};
      end
      KIND_LAST_SHORT: begin
        n_results = 2'd1;
      end
      KIND_LAST_LONG: begin
        if (keep) begin
          n_results = 2'd2;
          res0      = '{x: stage_q.mid_x, y: stage_q.mid_y, z: stage_q.mid_z,
                        path_end: 1'b0, run_last: 1'b0};
        end else begin
          n_results = 2'd1;
        end
      end
      default: n_results = 2'd0;
    endcase
  end

  assign res_sel      = phase_q ? res1 : res0;
  assign final_result = (n_results == 2'd1) || phase_q;
  assign out_free     = !out_valid_q || out_ready_i;
  assign load_out     = stage_valid_q && (n_results != 2'd0) && out_free;
  assign consume      = stage_valid_q
                        && ((n_results == 2'd0) || (out_free && final_result));
  assign pop_ready_o  = !stage_valid_q || consume;

  // Phase and output register control.
  always_comb begin
    phase_d = phase_q;
    if (load_out) begin
      phase_d = !final_result;
    end
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      phase_q       <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (pop_ready_o) begin
        stage_valid_q <= pop_valid_i;
      end
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (pop_ready_o && pop_valid_i) begin
      stage_q <= stage_d;
    end
    if (load_out) begin
      out_q <= res_sel;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kept_x_o    = out_q.x;
  assign kept_y_o    = out_q.y;
  assign kept_z_o    = out_q.z;
  assign path_end_o  = out_q.path_end;
  assign run_last_o  = out_q.run_last;

  // The second result belongs only to a request that has two.
  a_phase_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> stage_valid_q
                && ((stage_q.kind == KIND_SINGLE) || (stage_q.kind == KIND_LAST_LONG)))
    else $error("second result pending for a request with one result");

  // The end of a path is always the last result of its request.
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.path_end |-> out_q.run_last)
    else $error("path end without run last");

  // A request is never released while its first of two results waits.
  a_no_early_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out && !phase_q && (n_results == 2'd2) |=> stage_valid_q && phase_q)
    else $error("two-result request released after its first result");

  // A stalled result is not overwritten.
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !load_out)
    else $error("output register loaded while stalled");

endmodule

`default_nettype wire

// ----- src/collinear_waypoint_pruner.sv -----
// Collinear waypoint pruner. Waypoints stream in one per request on the input
// channel, path_last_i marking the final point of a path. The first and last
// points of every path are passed on; a middle point is passed on only if the
// path turns there in the xz plane (exact cross product) or changes height.
// A one-point path yields its point twice. The block accepts one waypoint per
// cycle while the output is taken and no waypoint yields two results. A
// waypoint's first result passes the request queue, the cross-product register
// and the output register. A waypoint that yields two results holds its request
// in the cross-product register until both have left, so the output
// register sets the sustained rate at one result per cycle while the output
// is taken; the two-entry queue lets input keep running in brief output stalls.
`default_nettype none

module collinear_waypoint_pruner
  import cwp_pkg::*;
#(
  parameter int HORIZ_BITS  = HORIZ_BITS_DEF,
  parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [HORIZ_BITS-1:0]  point_x_i,
  input  logic signed [HEIGHT_BITS-1:0] point_y_i,
  input  logic signed [HORIZ_BITS-1:0]  point_z_i,
  input  logic                          path_last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [HORIZ_BITS-1:0]  kept_x_o,
  output logic signed [HEIGHT_BITS-1:0] kept_y_o,
  output logic signed [HORIZ_BITS-1:0]  kept_z_o,
  output logic                          path_end_o,
  output logic                          run_last_o
);

  localparam int EntryW = $bits(kind_e) + 1 + 4 * (HORIZ_BITS + 1)
                          + 4 * HORIZ_BITS + 2 * HEIGHT_BITS;

  logic              push_valid, push_ready;
  logic [EntryW-1:0] push_data;
  logic              pop_valid, pop_ready;
  logic [EntryW-1:0] pop_data;

  // Front: window and classification.
  cwp_front #(
    .HORIZ_BITS  (HORIZ_BITS),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .point_z_i    (point_z_i),
    .path_last_i  (path_last_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // Request queue between the two halves.
  cwp_queue #(
    .WIDTH (EntryW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Back: decision and result emission.
  cwp_back #(
    .HORIZ_BITS  (HORIZ_BITS),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kept_x_o    (kept_x_o),
    .kept_y_o    (kept_y_o),
    .kept_z_o    (kept_z_o),
    .path_end_o  (path_end_o),
    .run_last_o  (run_last_o)
  );

endmodule

`default_nettype wire

// ----- bench/cwp_prune_checker.sv -----
`timescale 1ns / 100ps
// Checker for the collinear waypoint pruner: watches both request channels,
// predicts the kept waypoints and compares them in order. Uses cwp_pkg only.

module cwp_prune_checker
  import cwp_pkg::*;
#(
  parameter int HB = HORIZ_BITS_DEF,
  parameter int YB = HEIGHT_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic signed [HB-1:0] point_x_i,
  input  logic signed [YB-1:0] point_y_i,
  input  logic signed [HB-1:0] point_z_i,
  input  logic                 path_last_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic signed [HB-1:0] kept_x_i,
  input  logic signed [YB-1:0] kept_y_i,
  input  logic signed [HB-1:0] kept_z_i,
  input  logic                 path_end_i,
  input  logic                 run_last_i,
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   kept_count_o,
  output int                   pruned_count_o
);

  typedef struct packed {
    logic signed [HB-1:0] x;
    logic signed [YB-1:0] y;
    logic signed [HB-1:0] z;
    logic                 path_end;
    logic                 run_last;
  } kept_point_t;

  // Waypoints that the block still owes, oldest first.
  kept_point_t kept_fifo[$];

  // Own copy of the two-point window.
  logic [1:0]           seen_cnt = '0;
  logic signed [HB-1:0] prev_x = '0, prev_z = '0, mid_x = '0, mid_z = '0;
  logic signed [YB-1:0] prev_y = '0, mid_y = '0;

  initial begin
    fail_count_o   = 0;
    pending_o      = 0;
    kept_count_o   = 0;
    pruned_count_o = 0;
  end

  task automatic queue_point(input logic signed [HB-1:0] x, input logic signed [YB-1:0] y,
                             input logic signed [HB-1:0] z, input logic e, input logic l);
    kept_point_t w;
    w.x        = x;
    w.y        = y;
    w.z        = z;
    w.path_end = e;
    w.run_last = l;
    kept_fifo.push_back(w);
  endtask

  // A middle point stays if the path turns in xz or changes height around it.
  // Deltas and products are wide enough that nothing wraps.
  function automatic bit middle_needed(input logic signed [HB-1:0] nx,
                                       input logic signed [YB-1:0] ny,
                                       input logic signed [HB-1:0] nz);
    logic signed [HB:0]     ax, az, bx, bz;
    logic signed [2*HB+1:0] cross_a, cross_b;
    ax      = mid_x - prev_x;
    az      = mid_z - prev_z;
    bx      = nx - mid_x;
    bz      = nz - mid_z;
    cross_a = ax * bz;
    cross_b = az * bx;
    return (cross_a != cross_b) || (mid_y != prev_y) || (mid_y != ny);
  endfunction

  task automatic clear_window();
    seen_cnt = '0;
    prev_x   = '0;
    prev_y   = '0;
    prev_z   = '0;
    mid_x    = '0;
    mid_y    = '0;
    mid_z    = '0;
  endtask

  // Works out the kept waypoints that one accepted waypoint causes.
  task automatic prune_waypoint(input logic signed [HB-1:0] px, input logic signed [YB-1:0] py,
                                input logic signed [HB-1:0] pz, input logic last);
    if (seen_cnt == 2'd0) begin
      if (last) begin
        // A one-point path comes out twice.
        queue_point(px, py, pz, 1'b0, 1'b0);
        queue_point(px, py, pz, 1'b1, 1'b1);
        clear_window();
      end else begin
        queue_point(px, py, pz, 1'b0, 1'b1);
        mid_x    = px;
        mid_y    = py;
        mid_z    = pz;
        seen_cnt = 2'd1;
      end
    end else begin
      if (seen_cnt == 2'd2) begin
        if (middle_needed(px, py, pz)) begin
          queue_point(mid_x, mid_y, mid_z, 1'b0, !last);
        end else begin
          pruned_count_o++;
        end
      end
      if (last) begin
        queue_point(px, py, pz, 1'b1, 1'b1);
        clear_window();
      end else begin
        prev_x   = mid_x;
        prev_y   = mid_y;
        prev_z   = mid_z;
        mid_x    = px;
        mid_y    = py;
        mid_z    = pz;
        seen_cnt = 2'd2;
      end
    end
  endtask

  // Predict on each input request, then compare each output request.
  always @(posedge clk_i) begin
    kept_point_t want;
    if (!rst_ni) begin
      clear_window();
    end else begin
      if (in_valid_i && in_ready_i) begin
        prune_waypoint(point_x_i, point_y_i, point_z_i, path_last_i);
      end
      if (out_valid_i && out_ready_i) begin
        kept_count_o++;
        if (kept_fifo.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected kept waypoint x=%0d y=%0d z=%0d end=%0b last=%0b",
                   $time, kept_x_i, kept_y_i, kept_z_i, path_end_i, run_last_i);
        end else begin
          want = kept_fifo.pop_front();
          if (want.x !== kept_x_i || want.y !== kept_y_i || want.z !== kept_z_i ||
              want.path_end !== path_end_i || want.run_last !== run_last_i) begin
            fail_count_o++;
            $display("%0t: kept waypoint mismatch: expected x=%0d y=%0d z=%0d end=%0b last=%0b",
                     $time, $signed(want.x), $signed(want.y), $signed(want.z),
                     want.path_end, want.run_last);
            $display("%0t:                           actual x=%0d y=%0d z=%0d end=%0b last=%0b",
                     $time, kept_x_i, kept_y_i, kept_z_i, path_end_i, run_last_i);
          end
        end
      end
    end
    pending_o = kept_fifo.size();
  end

endmodule

// ----- bench/collinear_waypoint_pruner_tb.sv -----
`timescale 1ns / 100ps
// Top of the collinear waypoint pruner testbench: clock, reset, waypoint
// stimulus and output back-pressure. Needs cwp_pkg, the block and cwp_prune_checker.

module collinear_waypoint_pruner_tb;
  import cwp_pkg::*;

  localparam int HB          = HORIZ_BITS_DEF;
  localparam int YB          = HEIGHT_BITS_DEF;
  localparam int NUM_POINTS  = 850;
  localparam int HOLD_CYCLES = 60;

  localparam logic signed [HB-1:0] H_MAX = {1'b0, {(HB-1){1'b1}}};
  localparam logic signed [HB-1:0] H_MIN = {1'b1, {(HB-1){1'b0}}};
  localparam logic signed [YB-1:0] Y_MAX = {1'b0, {(YB-1){1'b1}}};
  localparam logic signed [YB-1:0] Y_MIN = {1'b1, {(YB-1){1'b0}}};

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic signed [HB-1:0] point_x_i   = '0;
  logic signed [YB-1:0] point_y_i   = '0;
  logic signed [HB-1:0] point_z_i   = '0;
  logic                 path_last_i = 1'b0;
  logic                 out_ready_i = 1'b0;
  logic                 in_ready_o;
  logic                 out_valid_o;
  logic signed [HB-1:0] kept_x_o;
  logic signed [YB-1:0] kept_y_o;
  logic signed [HB-1:0] kept_z_o;
  logic                 path_end_o;
  logic                 run_last_o;

  // Shared between the sender and the receiver.
  logic steady  = 1'b0;
  logic hold_go = 1'b0;

  int fail_count, pending, kept_count, pruned_count;
  int points_sent = 0;
  int paths_sent  = 0;

  collinear_waypoint_pruner dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .point_x_i  (point_x_i),
    .point_y_i  (point_y_i),
    .point_z_i  (point_z_i),
    .path_last_i(path_last_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .kept_x_o   (kept_x_o),
    .kept_y_o   (kept_y_o),
    .kept_z_o   (kept_z_o),
    .path_end_o (path_end_o),
    .run_last_o (run_last_o)
  );

  cwp_prune_checker #(.HB(HB), .YB(YB)) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .point_z_i     (point_z_i),
    .path_last_i   (path_last_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kept_x_i      (kept_x_o),
    .kept_y_i      (kept_y_o),
    .kept_z_i      (kept_z_o),
    .path_end_i    (path_end_o),
    .run_last_i    (run_last_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .kept_count_o  (kept_count),
    .pruned_count_o(pruned_count)
  );

  // Clock.
  always #10 clk_i = ~clk_i;

  // Hard stop in case the block hangs.
  initial begin
    #4000000;
    $display("Timeout: %0d kept waypoints still expected.", pending);
    $display("*** FAILED ***");
    $finish;
  end

  // Output side: random back-pressure, one long hold-off, and a steady stretch.
  initial begin : receiver
    bit held;
    held = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_go && !held) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
      end else if (steady) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= 33);
      end
    end
  end

  // Offers one waypoint and waits until the block takes the request.
  task automatic send_point(input logic signed [HB-1:0] x, input logic signed [YB-1:0] y,
                            input logic signed [HB-1:0] z, input logic last);
    if (!steady) begin
      while ($urandom_range(0, 99) < 33) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i  <= 1'b1;
    point_x_i   <= x;
    point_y_i   <= y;
    point_z_i   <= z;
    path_last_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    points_sent++;
    if (last) paths_sent++;
  endtask

  // One random path. Half the paths are lines or near-lines so that the
  // keep-or-prune decision is exercised both ways.
  task automatic send_random_path();
    int len, shape, sx, sy, sz, dx, dy, dz, x, y, z;
    len   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
    shape = $urandom_range(0, 3);
    sx    = $urandom;
    sy    = $urandom;
    sz    = $urandom;
    dx    = $urandom_range(0, 16) - 8;
    dz    = $urandom_range(0, 16) - 8;
    dy    = 0;
    for (int i = 0; i < len; i++) begin
      case (shape)
        0: begin
          x = $urandom;
          y = $urandom;
          z = $urandom;
        end
        1: begin
          x = sx + i * dx;
          y = sy;
          z = sz + i * dz;
        end
        2: begin
          x = sx + i * dx;
          z = sz + i * dz;
          if ($urandom_range(0, 3) == 0) x = x + $urandom_range(0, 2) - 1;
          if ($urandom_range(0, 4) == 0) dy = dy + $urandom_range(0, 2) - 1;
          y = sy + dy;
        end
        default: begin
          x = $urandom_range(0, 4) - 2;
          y = $urandom_range(0, 1);
          z = $urandom_range(0, 4) - 2;
        end
      endcase
      send_point(HB'(x), YB'(y), HB'(z), i == len - 1);
    end
  endtask

  // Stimulus and verdict.
  initial begin : sender
    bit paused;
    paused = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // One-point paths at both extremes, then a two-point path.
    send_point(H_MAX, Y_MAX, H_MAX, 1'b1);
    send_point(H_MIN, Y_MIN, H_MIN, 1'b1);
    send_point(0, 0, 0, 1'b0);
    send_point(-1, -1, -1, 1'b1);
    // Straight line over the full coordinate range: the middle is pruned.
    send_point(H_MIN, 5, H_MIN, 1'b0);
    send_point(0, 5, 0, 1'b0);
    send_point(H_MAX, 5, H_MAX, 1'b1);
    // Right-angle turn: the middle is kept.
    send_point(0, 0, 0, 1'b0);
    send_point(10, 0, 0, 1'b0);
    send_point(10, 0, 10, 1'b1);
    // Straight, but the height differs from the point before.
    send_point(0, 1, 0, 1'b0);
    send_point(1, 2, 1, 1'b0);
    send_point(2, 2, 2, 1'b1);
    // Straight, but the height differs from the point after.
    send_point(0, 3, 0, 1'b0);
    send_point(1, 3, 1, 1'b0);
    send_point(2, 4, 2, 1'b1);
    // Repeated point and a reversal along one line: both pruned.
    send_point(7, 7, 7, 1'b0);
    send_point(7, 7, 7, 1'b0);
    send_point(7, 7, 7, 1'b1);
    send_point(0, 0, 0, 1'b0);
    send_point(5, 0, 5, 1'b0);
    send_point(0, 0, 0, 1'b1);
    // Zigzag between extreme corners with height steps.
    send_point(H_MAX, Y_MIN, H_MIN, 1'b0);
    send_point(H_MIN, Y_MIN, H_MAX, 1'b0);
    send_point(H_MAX, Y_MIN, H_MAX, 1'b0);
    send_point(H_MAX, Y_MAX, H_MAX, 1'b0);
    send_point(0, 0, 0, 1'b1);

    while (points_sent < NUM_POINTS) begin
      // Long output hold-off while the input keeps coming.
      if (points_sent >= 250) hold_go <= 1'b1;
      // Let the block drain completely once.
      if (!paused && points_sent >= 500) begin
        paused = 1'b1;
        in_valid_i <= 1'b0;
        do @(negedge clk_i); while (pending != 0);
        @(posedge clk_i);
      end
      // Back-to-back stretch with no idling on either side.
      steady <= (points_sent >= 600 && points_sent < 720);
      send_random_path();
    end
    in_valid_i <= 1'b0;
    steady     <= 1'b0;

    // Drain, then keep the clock running so that stray results can show.
    do @(negedge clk_i); while (pending != 0);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d waypoints in %0d paths under random idling, a long output hold-off,",
             points_sent, paths_sent);
    $display("a full drain and a back-to-back stretch; %0d kept, %0d middle points pruned.",
             kept_count, pruned_count);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d kept waypoints never came.", fail_count, pending);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/cwp_pkg.sv
src/cwp_queue.sv
src/cwp_front.sv
src/cwp_back.sv
src/collinear_waypoint_pruner.sv
bench/cwp_prune_checker.sv
bench/collinear_waypoint_pruner_tb.sv
